// ===== design/wppe_pkg.sv =====
// Shared types and constants for the WS2812 pixel PWM encoder.
package wppe_pkg;

    localparam logic [4:0] LAST_BIT            = 5'd23;
    localparam logic [7:0] RESET_SLOTS_DEFAULT = 8'd50;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        REG_LED_COUNT   = 2'd0,
        REG_ONE_DUTY    = 2'd1,
        REG_ZERO_DUTY   = 2'd2,
        REG_RESET_SLOTS = 2'd3
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic copy_step;
        logic tick_finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic start_copy;
        logic tick_read;
        logic copy_done;
    } sts_t;

endpackage

// ===== design/wppe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wppe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/wppe_ctrl.sv =====
// Controller: sequences clearing pass, input acceptance, snapshot copy and slot reads.
module wppe_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  wppe_pkg::sts_t  sts,
    output wppe_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_TICK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = sts.out_free;
                cmd.accept = in_valid && sts.out_free;
                if (cmd.accept && sts.tick_read)
                begin
                    state_next = ST_TICK;
                end
                else if (cmd.accept && sts.start_copy)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (sts.copy_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                cmd.tick_finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/wppe_dp.sv =====
// Datapath: registers, pixel store, frame snapshot, slot pointers and result register.
module wppe_dp #(
    parameter int MAX_LEDS = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  wppe_pkg::cmd_t  cmd,
    output wppe_pkg::sts_t  sts,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic [1:0]      req_type,
    input  logic [7:0]      led_index,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     duty,
    output logic            slot_valid,
    output logic            last_slot,
    output logic            accepted,
    output logic            busy_now
);

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W = ($clog2(MAX_LEDS + 1) > 9) ? $clog2(MAX_LEDS + 1) : 9;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEDS);

    // configuration
    logic [8:0]  led_count_reg;
    logic [15:0] one_duty_reg;
    logic [15:0] zero_duty_reg;
    logic [7:0]  reset_slots_reg;

    // frame settings latched at start
    logic [CNT_W-1:0] fr_leds_reg;
    logic [7:0]       fr_reset_reg;
    logic [15:0]      fr_one_reg;
    logic [15:0]      fr_zero_reg;

    // slot position, split as LED / bit / trailing reset slot
    logic             busy_reg,    busy_next;
    logic [CNT_W-1:0] led_ptr_reg, led_ptr_next;
    logic [4:0]       bit_ptr_reg, bit_ptr_next;
    logic [7:0]       rst_ptr_reg, rst_ptr_next;

    logic [CNT_W-1:0] clr_ctr_reg;
    logic [CNT_W-1:0] rd_ctr_reg;
    logic             wr_pend_reg;
    logic [AW-1:0]    wr_addr_reg;

    logic             out_valid_reg;
    logic [15:0]      duty_reg;
    logic             slot_valid_reg;
    logic             last_slot_reg;
    logic             accepted_reg;
    logic             busy_now_reg;

    logic [CNT_W-1:0] led_count_ext;
    logic [CNT_W-1:0] clamped;
    logic [CNT_W-1:0] idx_ext;
    logic             is_write, is_start, is_tick;
    logic             write_ok, start_ok, start_nonempty;
    logic             copy_rd;
    logic             load_imm;

    logic             pix_we;
    logic [AW-1:0]    pix_waddr;
    logic [23:0]      pix_wdata;
    logic [23:0]      pix_rdata;
    logic [23:0]      snap_rdata;

    logic             data_phase;
    logic [4:0]       bit_sel;
    logic             cur_bit;
    logic             is_last;
    logic [15:0]      tick_duty;

    assign cfg_ready = 1'b1;

    assign led_count_ext  = CNT_W'(led_count_reg);
    assign clamped        = (led_count_ext > MAX_CNT) ? MAX_CNT : led_count_ext;
    assign idx_ext        = CNT_W'(led_index);

    assign is_write       = (req_type == wppe_pkg::REQ_WRITE);
    assign is_start       = (req_type == wppe_pkg::REQ_START);
    assign is_tick        = (req_type == wppe_pkg::REQ_TICK);
    assign write_ok       = is_write && (idx_ext < clamped);
    assign start_ok       = is_start && !busy_reg;
    assign start_nonempty = (clamped != '0) || (reset_slots_reg != '0);

    assign sts.clear_last = (clr_ctr_reg == MAX_CNT - 1'b1);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.start_copy = start_ok && (clamped != '0);
    assign sts.tick_read  = is_tick && busy_reg;
    assign sts.copy_done  = (rd_ctr_reg == fr_leds_reg) && !wr_pend_reg;

    assign copy_rd  = cmd.copy_step && (rd_ctr_reg < fr_leds_reg);
    assign load_imm = cmd.accept && !sts.tick_read;

    // pixel store: clearing pass after reset, then pixel writes
    always_comb
    begin
        if (cmd.clear_step)
        begin
            pix_we    = 1'b1;
            pix_waddr = clr_ctr_reg[AW-1:0];
            pix_wdata = '0;
        end
        else
        begin
            pix_we    = cmd.accept && write_ok;
            pix_waddr = idx_ext[AW-1:0];
            pix_wdata = {green, red, blue};
        end
    end

    wppe_ram #(
        .WIDTH (24),
        .DEPTH (MAX_LEDS)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .re    (copy_rd),
        .raddr (rd_ctr_reg[AW-1:0]),
        .rdata (pix_rdata)
    );

    wppe_ram #(
        .WIDTH (24),
        .DEPTH (MAX_LEDS)
    ) u_snap_ram (
        .clk   (clk),
        .we    (wr_pend_reg),
        .waddr (wr_addr_reg),
        .wdata (pix_rdata),
        .re    (cmd.accept && sts.tick_read),
        .raddr (led_ptr_reg[AW-1:0]),
        .rdata (snap_rdata)
    );

    // slot evaluation, in the cycle after the snapshot read
    assign data_phase = (led_ptr_reg < fr_leds_reg);
    assign bit_sel    = wppe_pkg::LAST_BIT - bit_ptr_reg;
    assign cur_bit    = snap_rdata[bit_sel];
    assign tick_duty  = data_phase ? (cur_bit ? fr_one_reg : fr_zero_reg) : 16'd0;
    assign is_last    = data_phase
                        ? ((led_ptr_reg == fr_leds_reg - 1'b1)
                           && (bit_ptr_reg == wppe_pkg::LAST_BIT)
                           && (fr_reset_reg == '0))
                        : (rst_ptr_reg == fr_reset_reg - 1'b1);

    always_comb
    begin
        busy_next    = busy_reg;
        led_ptr_next = led_ptr_reg;
        bit_ptr_next = bit_ptr_reg;
        rst_ptr_next = rst_ptr_reg;
        if (cmd.accept && start_ok)
        begin
            busy_next    = start_nonempty;
            led_ptr_next = '0;
            bit_ptr_next = '0;
            rst_ptr_next = '0;
        end
        else if (cmd.tick_finish)
        begin
            if (is_last)
            begin
                busy_next    = 1'b0;
                led_ptr_next = '0;
                bit_ptr_next = '0;
                rst_ptr_next = '0;
            end
            else if (data_phase)
            begin
                if (bit_ptr_reg == wppe_pkg::LAST_BIT)
                begin
                    bit_ptr_next = '0;
                    led_ptr_next = led_ptr_reg + 1'b1;
                end
                else
                begin
                    bit_ptr_next = bit_ptr_reg + 1'b1;
                end
            end
            else
            begin
                rst_ptr_next = rst_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg   <= '0;
            one_duty_reg    <= '0;
            zero_duty_reg   <= '0;
            reset_slots_reg <= wppe_pkg::RESET_SLOTS_DEFAULT;
            fr_leds_reg     <= '0;
            fr_reset_reg    <= '0;
            fr_one_reg      <= '0;
            fr_zero_reg     <= '0;
            busy_reg        <= 1'b0;
            led_ptr_reg     <= '0;
            bit_ptr_reg     <= '0;
            rst_ptr_reg     <= '0;
            clr_ctr_reg     <= '0;
            rd_ctr_reg      <= '0;
            wr_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    wppe_pkg::REG_LED_COUNT:   led_count_reg   <= cfg_data[8:0];
                    wppe_pkg::REG_ONE_DUTY:    one_duty_reg    <= cfg_data;
                    wppe_pkg::REG_ZERO_DUTY:   zero_duty_reg   <= cfg_data;
                    wppe_pkg::REG_RESET_SLOTS: reset_slots_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (cmd.clear_step)
            begin
                clr_ctr_reg <= clr_ctr_reg + 1'b1;
            end

            if (cmd.accept && start_ok)
            begin
                fr_leds_reg  <= clamped;
                fr_reset_reg <= reset_slots_reg;
                fr_one_reg   <= one_duty_reg;
                fr_zero_reg  <= zero_duty_reg;
                rd_ctr_reg   <= '0;
            end
            else if (copy_rd)
            begin
                rd_ctr_reg <= rd_ctr_reg + 1'b1;
            end
            wr_pend_reg <= copy_rd;

            busy_reg    <= busy_next;
            led_ptr_reg <= led_ptr_next;
            bit_ptr_reg <= bit_ptr_next;
            rst_ptr_reg <= rst_ptr_next;

            if (load_imm || cmd.tick_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (copy_rd)
        begin
            wr_addr_reg <= rd_ctr_reg[AW-1:0];
        end
        if (cmd.tick_finish)
        begin
            duty_reg       <= tick_duty;
            slot_valid_reg <= 1'b1;
            last_slot_reg  <= is_last;
            accepted_reg   <= 1'b0;
            busy_now_reg   <= !is_last;
        end
        else if (load_imm)
        begin
            duty_reg       <= '0;
            slot_valid_reg <= 1'b0;
            last_slot_reg  <= 1'b0;
            accepted_reg   <= write_ok || start_ok;
            busy_now_reg   <= start_ok ? start_nonempty : busy_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign duty       = duty_reg;
    assign slot_valid = slot_valid_reg;
    assign last_slot  = last_slot_reg;
    assign accepted   = accepted_reg;
    assign busy_now   = busy_now_reg;

endmodule

// ===== design/ws2812_pixel_pwm_encoder.sv =====
// Top level of the WS2812 pixel PWM encoder: controller plus datapath.
//
// Usage:
//   cfg channel  - cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 LED count,
//                  1 one-bit duty, 2 zero-bit duty, 3 reset slot count. Always ready.
//   in channel   - one word per request: write pixel, start frame, slot tick, or none.
//   out channel  - exactly one result word per request word, in order.
// Result timing:
//   write pixel, start, tick while idle, none: result registered at accept.
//   tick while busy: through the registered read of the frame snapshot RAM and ST_TICK.
//   start of a frame with N LEDs: the snapshot copy then holds in_ready low while
//   it copies one LED per cycle through the single pixel RAM read port.
//   The next word can be taken in the cycle the pending result is taken.
// Reset:
//   the control and config registers go to their defaults and a clearing pass zeroes
//   the pixel store with in_ready low throughout; config writes are taken during it.
// Stall:
//   while out_ready is low the result holds in the output register and in_ready drops.
module ws2812_pixel_pwm_encoder #(
    parameter int MAX_LEDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  led_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] duty,
    output logic        slot_valid,
    output logic        last_slot,
    output logic        accepted,
    output logic        busy_now
);

    wppe_pkg::cmd_t cmd;
    wppe_pkg::sts_t sts;

    // sequencing: clear sweep, accept, snapshot copy, slot read
    wppe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage, frame pointers and the result register
    wppe_dp #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .led_index  (led_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .duty       (duty),
        .slot_valid (slot_valid),
        .last_slot  (last_slot),
        .accepted   (accepted),
        .busy_now   (busy_now)
    );

endmodule

// ===== bench/ws2812_frame_checker.sv =====
// Checker for the WS2812 pixel PWM encoder: predicts every result word and compares it.
module ws2812_frame_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  led_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] duty,
    input  logic        slot_valid,
    input  logic        last_slot,
    input  logic        accepted,
    input  logic        busy_now,

    output int unsigned fail_count,
    output int unsigned words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LED_SLOTS    = 256;
    localparam int unsigned BITS_PER_LED = 24;

    typedef struct packed {
        logic [15:0] duty;
        logic        slot_valid;
        logic        last_slot;
        logic        accepted;
        logic        busy_now;
    } slot_word_t;

    slot_word_t  slot_words_due[$];

    // register copies
    logic [8:0]  led_count_reg;
    logic [15:0] one_duty_reg;
    logic [15:0] zero_duty_reg;
    logic [7:0]  reset_slots_reg;

    // pixel store, frame snapshot and frame settings latched at start
    logic [23:0] pixel_store [LED_SLOTS];
    logic [23:0] frame_pixels [LED_SLOTS];
    int unsigned frame_leds;
    int unsigned frame_reset_slots;
    logic [15:0] frame_one_duty;
    logic [15:0] frame_zero_duty;
    int unsigned slot_pos;
    logic        sending;

    function automatic int unsigned strip_length();
        return (led_count_reg > LED_SLOTS) ? LED_SLOTS : int'(led_count_reg);
    endfunction

    function automatic slot_word_t encode_request(input wppe_pkg::req_t kind,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] r, g, b);
        slot_word_t  w;
        int unsigned pixel_slots;
        logic [23:0] grb;
        w = '0;
        case (kind)
            wppe_pkg::REQ_WRITE: begin
                if (idx < strip_length()) begin
                    pixel_store[idx] = {g, r, b};
                    w.accepted = 1'b1;
                end
            end
            wppe_pkg::REQ_START: begin
                if (!sending) begin
                    frame_pixels      = pixel_store;
                    frame_leds        = strip_length();
                    frame_reset_slots = reset_slots_reg;
                    frame_one_duty    = one_duty_reg;
                    frame_zero_duty   = zero_duty_reg;
                    slot_pos          = 0;
                    sending    = (frame_leds * BITS_PER_LED + frame_reset_slots) != 0;
                    w.accepted = 1'b1;
                end
            end
            wppe_pkg::REQ_TICK: begin
                if (sending) begin
                    pixel_slots = frame_leds * BITS_PER_LED;
                    if (slot_pos < pixel_slots) begin
                        grb    = frame_pixels[slot_pos / BITS_PER_LED];
                        w.duty = grb[wppe_pkg::LAST_BIT - (slot_pos % BITS_PER_LED)] ?
                                 frame_one_duty : frame_zero_duty;
                    end
                    w.slot_valid = 1'b1;
                    if (slot_pos + 1 >= pixel_slots + frame_reset_slots) begin
                        w.last_slot = 1'b1;
                        sending     = 1'b0;
                        slot_pos    = 0;
                    end else begin
                        slot_pos++;
                    end
                end
            end
            default: ;
        endcase
        w.busy_now = sending;
        return w;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        slot_word_t want;
        if (!rst_n) begin
            led_count_reg     = '0;
            one_duty_reg      = '0;
            zero_duty_reg     = '0;
            reset_slots_reg   = wppe_pkg::RESET_SLOTS_DEFAULT;
            frame_leds        = 0;
            frame_reset_slots = 0;
            frame_one_duty    = '0;
            frame_zero_duty   = '0;
            slot_pos          = 0;
            sending           = 1'b0;
            for (int i = 0; i < LED_SLOTS; i++) begin
                pixel_store[i]  = '0;
                frame_pixels[i] = '0;
            end
            slot_words_due.delete();
            fail_count = 0;
            words_due <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (wppe_pkg::reg_idx_t'(cfg_index))
                    wppe_pkg::REG_LED_COUNT:   led_count_reg   = cfg_data[8:0];
                    wppe_pkg::REG_ONE_DUTY:    one_duty_reg    = cfg_data;
                    wppe_pkg::REG_ZERO_DUTY:   zero_duty_reg   = cfg_data;
                    wppe_pkg::REG_RESET_SLOTS: reset_slots_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                slot_words_due.push_back(encode_request(wppe_pkg::req_t'(req_type),
                                                        led_index, red, green, blue));
            if (out_valid && out_ready) begin
                if (slot_words_due.size() == 0) begin
                    $error("result word with no request outstanding");
                    fail_count++;
                end else begin
                    want = slot_words_due.pop_front();
                    check_field("duty", want.duty, duty);
                    check_field("slot_valid", want.slot_valid, slot_valid);
                    check_field("last_slot", want.last_slot, last_slot);
                    check_field("accepted", want.accepted, accepted);
                    check_field("busy_now", want.busy_now, busy_now);
                end
            end
            words_due <= slot_words_due.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the WS2812 pixel PWM encoder bench: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LED_SLOTS    = 256;
    localparam int unsigned RANDOM_WORDS = 400;
    // The limit leaves room for every word to carry a sender gap and a receiver
    // stall, plus the snapshot copies and the clearing pass.
    localparam int unsigned CYCLE_LIMIT  = 600_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type  = '0;
    logic [7:0]  led_index = '0;
    logic [7:0]  red       = '0;
    logic [7:0]  green     = '0;
    logic [7:0]  blue      = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] duty;
    logic        slot_valid;
    logic        last_slot;
    logic        accepted;
    logic        busy_now;

    int unsigned fail_count;
    int unsigned words_due;

    // Idling knobs, in percent per word / per cycle. quiet turns all idling off.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    bit          quiet     = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    // Stimulus-side view of the settings, only to know how long a frame runs.
    logic [8:0]  led_count_set   = '0;
    logic [7:0]  reset_slots_set = wppe_pkg::RESET_SLOTS_DEFAULT;
    int unsigned slots_left      = 0;
    int unsigned words_sent      = 0;

    ws2812_pixel_pwm_encoder #(
        .MAX_LEDS(LED_SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .led_index  (led_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .duty       (duty),
        .slot_valid (slot_valid),
        .last_slot  (last_slot),
        .accepted   (accepted),
        .busy_now   (busy_now)
    );

    ws2812_frame_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .led_index  (led_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .duty       (duty),
        .slot_valid (slot_valid),
        .last_slot  (last_slot),
        .accepted   (accepted),
        .busy_now   (busy_now),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stall bursts, none once quiet is set.
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_ready  <= !rst_n ? 1'b0 : 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end else begin
            out_ready  <= 1'b1;
        end
    end

    // Mostly random bytes, with the all-zeros and all-ones corners pulled in often.
    function automatic logic [7:0] color_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] duty_value();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One request word. valid stays high after acceptance; the next call either
    // loads the next word straight away or first drops valid for a gap.
    task automatic send(input wppe_pkg::req_t kind, input logic [7:0] idx,
                        input logic [7:0] r, g, b);
        int unsigned leds;
        if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        led_index <= idx;
        red       <= r;
        green     <= g;
        blue      <= b;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        // Track the frame length so well-formed sequences tick a frame to its end.
        leds = (led_count_set > LED_SLOTS) ? LED_SLOTS : int'(led_count_set);
        if (kind == wppe_pkg::REQ_START && slots_left == 0)
            slots_left = leds * 24 + reset_slots_set;
        else if (kind == wppe_pkg::REQ_TICK && slots_left != 0)
            slots_left--;
    endtask

    // Any request type; half of the indexes lie near the strip so some writes land in range.
    task automatic send_noise(input int unsigned leds);
        send(wppe_pkg::req_t'($urandom_range(0, 3)),
             $urandom_range(0, 1) ? 8'($urandom_range(0, leds)) : 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input wppe_pkg::reg_idx_t which, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (which == wppe_pkg::REG_LED_COUNT)
            led_count_set = value[8:0];
        else if (which == wppe_pkg::REG_RESET_SLOTS)
            reset_slots_set = value[7:0];
    endtask

    // Hold the sender off until every predicted word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
    endtask

    task automatic finish_frame();
        while (slots_left != 0)
            send(wppe_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    endtask

    // One phase: fresh settings, then either a well-formed frame (pixel writes,
    // start, ticks) with noise sprinkled in, or a burst of unstructured words.
    task automatic run_phase(input bit long_tail);
        int unsigned leds;
        int unsigned tail;
        int unsigned n;
        wait_drained();
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        leds = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        tail = long_tail ? 255 : (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12));
        // upper data bits are don't-care for the narrow registers
        write_reg(wppe_pkg::REG_LED_COUNT, {7'($urandom), 9'(leds)});
        if ($urandom_range(0, 3) != 0)
            write_reg(wppe_pkg::REG_ONE_DUTY, duty_value());
        if ($urandom_range(0, 3) != 0)
            write_reg(wppe_pkg::REG_ZERO_DUTY, duty_value());
        write_reg(wppe_pkg::REG_RESET_SLOTS, {8'($urandom), 8'(tail)});
        cfg_valid <= 1'b0;

        if ($urandom_range(0, 4) != 0) begin
            for (int unsigned i = 0; i < leds; i++) begin
                if ($urandom_range(0, 11) == 0)
                    send_noise(leds);
                send(wppe_pkg::REQ_WRITE, 8'(i), color_byte(), color_byte(), color_byte());
            end
            send(wppe_pkg::REQ_START, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
            n = slots_left;
            // now and then stop early so the frame runs on into the next settings
            if ($urandom_range(0, 5) == 0)
                n = $urandom_range(0, n);
            for (int unsigned i = 0; i < n; i++) begin
                if ($urandom_range(0, 11) == 0)
                    send_noise(leds);
                send(wppe_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
            end
        end else begin
            repeat ($urandom_range(20, 60))
                send_noise(leds);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct   = 15;
        stall_pct = 15;

        // Defaults after reset: no LEDs, 50 reset slots, both duties zero.
        send(wppe_pkg::REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);     // tick while idle
        send(wppe_pkg::REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);     // unused request type
        send(wppe_pkg::REQ_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF);    // no LEDs: write dropped
        send(wppe_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);    // reset slots only
        send(wppe_pkg::REQ_NONE, 8'h00, 8'h00, 8'h00, 8'h00);     // unused type while busy
        finish_frame();

        // Empty frame: accepted but never goes busy.
        wait_drained();
        write_reg(wppe_pkg::REG_LED_COUNT, 16'd0);
        write_reg(wppe_pkg::REG_RESET_SLOTS, 16'd0);
        cfg_valid <= 1'b0;
        send(wppe_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send(wppe_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

        // Two LEDs, full-scale one duty, zero duty of zero, one reset slot.
        wait_drained();
        write_reg(wppe_pkg::REG_LED_COUNT, 16'd2);
        write_reg(wppe_pkg::REG_ONE_DUTY, 16'hFFFF);
        write_reg(wppe_pkg::REG_ZERO_DUTY, 16'h0000);
        write_reg(wppe_pkg::REG_RESET_SLOTS, 16'd1);
        cfg_valid <= 1'b0;
        send(wppe_pkg::REQ_WRITE, 8'd2, 8'hFF, 8'hFF, 8'hFF);     // just past the strip
        send(wppe_pkg::REQ_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);   // far out of range
        send(wppe_pkg::REQ_WRITE, 8'd0, 8'h00, 8'hFF, 8'hA5);
        send(wppe_pkg::REQ_WRITE, 8'd1, 8'hFF, 8'h00, 8'h5A);
        send(wppe_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        send(wppe_pkg::REQ_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF);    // start while busy
        send(wppe_pkg::REQ_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);     // snapshot holds
        // Settings change mid-frame; the frame keeps what it latched at start.
        wait_drained();
        write_reg(wppe_pkg::REG_ONE_DUTY, 16'h1234);
        write_reg(wppe_pkg::REG_RESET_SLOTS, 16'd255);
        cfg_valid <= 1'b0;
        finish_frame();
        send(wppe_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

        // LED count above the store size clamps; the top entry becomes writable.
        wait_drained();
        write_reg(wppe_pkg::REG_LED_COUNT, 16'h01FF);
        cfg_valid <= 1'b0;
        send(wppe_pkg::REQ_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        send(wppe_pkg::REQ_WRITE, 8'd128, 8'h00, 8'h00, 8'h00);
        wait_drained();
        write_reg(wppe_pkg::REG_LED_COUNT, 16'd256);
        cfg_valid <= 1'b0;
        send(wppe_pkg::REQ_WRITE, 8'd255, 8'h00, 8'h00, 8'h00);

        // Random phases; the second one carries the longest reset tail.
        words_sent = 0;
        for (int unsigned phase = 0; words_sent < RANDOM_WORDS; phase++)
            run_phase(phase == 1);

        // Last part, no idling: a clamped full-length strip is started and ticked for a
        // while. It is left running at the end, which is fine.
        finish_frame();
        wait_drained();
        quiet = 1'b1;
        write_reg(wppe_pkg::REG_LED_COUNT, 16'hFFFF);
        write_reg(wppe_pkg::REG_ONE_DUTY, duty_value());
        write_reg(wppe_pkg::REG_ZERO_DUTY, duty_value());
        write_reg(wppe_pkg::REG_RESET_SLOTS, 16'hFFFF);
        cfg_valid <= 1'b0;
        send(wppe_pkg::REQ_WRITE, 8'd255, color_byte(), color_byte(), color_byte());
        send(wppe_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (60)
            send(wppe_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
        send(wppe_pkg::REQ_WRITE, 8'd0, color_byte(), color_byte(), color_byte());
        send(wppe_pkg::REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

        // Drain, then give the registered tick path room to show any stray word.
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wppe_pkg.sv
design/wppe_ram.sv
design/wppe_ctrl.sv
design/wppe_dp.sv
design/ws2812_pixel_pwm_encoder.sv
bench/ws2812_frame_checker.sv
bench/tb_top.sv
